### src/wpfc_pkg.sv
// Package: shared types and constants of the wildcard packet filter classifier.
package wpfc_pkg;

	localparam int TableEntries = 8;
	localparam int EntryW = 3;
	localparam int WordSelW = 3;
	localparam int AddrW = EntryW + WordSelW;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_DROP  = 3'd1,
		ACT_TCP   = 3'd2,
		ACT_RTP   = 3'd3,
		ACT_UDP   = 3'd4
	} action_t;

	typedef enum logic [WordSelW-1:0] {
		W_ANY_IP   = 3'd0,
		W_DST_IP   = 3'd1,
		W_SRC_IP   = 3'd2,
		W_ANY_PORT = 3'd3,
		W_DST_PORT = 3'd4,
		W_SRC_PORT = 3'd5,
		W_SSRC     = 3'd6,
		W_FLAGS    = 3'd7
	} word_sel_t;

	localparam logic [1:0] PROTO_TCP = 2'd0;
	localparam logic [1:0] PROTO_UDP = 2'd1;

	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	// word travelling down the cell chain with the running search results
	typedef struct packed {
		logic              valid;
		logic              op;
		logic [AddrW-1:0]  waddr;
		logic [31:0]       wdata;
		logic [1:0]        protocol;
		logic              is_ipv6;
		logic [31:0]       src_ip;
		logic [31:0]       dst_ip;
		logic [15:0]       src_port;
		logic [15:0]       dst_port;
		logic              rtp_ok;
		logic [31:0]       rtp_ssrc;
		logic [6:0]        rtp_pt;
		logic              want_rtp;
		logic              raw_hit;
		logic [EntryW-1:0] raw_idx;
		logic              rtp_hit;
		logic [EntryW-1:0] rtp_idx;
	} cell_bus_t;

endpackage

### src/wpfc_cell.sv
// One filter entry cell: holds the entry, applies writes, folds its match into the word.
module wpfc_cell
	import wpfc_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [3:0] num_filters,
	input  cell_bus_t  bus_i,
	output cell_bus_t  bus_o
);

	logic [31:0] any_ip_q, dst_ip_q, src_ip_q, ssrc_q;
	logic [15:0] any_port_q, dst_port_q, src_port_q;
	logic [2:0]  flags_q;
	logic [6:0]  pt_q;

	logic      wr_en;
	logic      active;
	logic      ip_pass, port_pass, rtp_pass, tuple_pass;
	cell_bus_t bus_s1;
	cell_bus_t nxt;

	assign wr_en = adv && bus_i.valid && (bus_i.op == OP_WRITE) &&
		(bus_i.waddr[AddrW-1:WordSelW] == EntryW'(IDX));
	assign active = 4'(IDX) < num_filters;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_ip_q   <= '0;
			dst_ip_q   <= '0;
			src_ip_q   <= '0;
			any_port_q <= '0;
			dst_port_q <= '0;
			src_port_q <= '0;
			ssrc_q     <= '0;
			flags_q    <= '0;
			pt_q       <= '0;
		end else if (wr_en) begin
			unique case (word_sel_t'(bus_i.waddr[WordSelW-1:0]))
				W_ANY_IP:   any_ip_q   <= bus_i.wdata;
				W_DST_IP:   dst_ip_q   <= bus_i.wdata;
				W_SRC_IP:   src_ip_q   <= bus_i.wdata;
				W_ANY_PORT: any_port_q <= bus_i.wdata[15:0];
				W_DST_PORT: dst_port_q <= bus_i.wdata[15:0];
				W_SRC_PORT: src_port_q <= bus_i.wdata[15:0];
				W_SSRC:     ssrc_q     <= bus_i.wdata;
				W_FLAGS: begin
					flags_q <= bus_i.wdata[2:0];
					pt_q    <= bus_i.wdata[14:8];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (bus_i.is_ipv6) begin
			ip_pass = (any_ip_q == '0) && (dst_ip_q == '0) && (src_ip_q == '0);
		end else if (any_ip_q != '0) begin
			ip_pass = (any_ip_q == bus_i.dst_ip) || (any_ip_q == bus_i.src_ip);
		end else begin
			ip_pass = ((dst_ip_q == '0) || (dst_ip_q == bus_i.dst_ip)) &&
				((src_ip_q == '0) || (src_ip_q == bus_i.src_ip));
		end
		if (any_port_q != '0) begin
			port_pass = (any_port_q == bus_i.dst_port) || (any_port_q == bus_i.src_port);
		end else begin
			port_pass = ((dst_port_q == '0) || (dst_port_q == bus_i.dst_port)) &&
				((src_port_q == '0) || (src_port_q == bus_i.src_port));
		end
		rtp_pass = (!flags_q[0] || (ssrc_q == bus_i.rtp_ssrc)) &&
			(!flags_q[1] || (pt_q == bus_i.rtp_pt));
		tuple_pass = active && ip_pass && port_pass;

		nxt = bus_i;
		nxt.want_rtp = bus_i.want_rtp || (active && (flags_q != '0));
		if (!bus_i.raw_hit && tuple_pass) begin
			nxt.raw_hit = 1'b1;
			nxt.raw_idx = EntryW'(IDX);
		end
		if (!bus_i.rtp_hit && tuple_pass && rtp_pass) begin
			nxt.rtp_hit = 1'b1;
			nxt.rtp_idx = EntryW'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_s1 <= '0;
		end else if (adv) begin
			bus_s1 <= nxt;
		end
	end

	assign bus_o = bus_s1;

endmodule

### src/wildcard_packet_filter_classifier_top.sv
// Top level: config register, filter cell chain, action decision and output register.
//
// Usage: items enter on the in_valid/in_stall channel. A word with op = 0 stores
// write_value into filter word write_address (entry*8 + word); op = 1 classifies
// a parsed header. Every item gives exactly one result word on out_valid/out_stall:
// action, match_valid and match_index (write items return action 0).
// The item walks a chain of one cell per filter entry, one cell per cycle unless
// the output stalls, each cell holding its entry and folding its match into the
// word; writes update the addressed cell as they pass, so items see the table in
// arrival order. The item is registered in every cell and then in the output register
// (cells = min(MAX_FILTERS, 8)); one item enters every cycle unless stalled. Writes
// to entries at or above the cell count are dropped; they can never be active.
// num_filters is written over the APB port at address 0; write it only while idle.
// Reset clears the table, num_filters and all valid bits.
// When the receiver stalls a valid result, the whole chain holds and in_stall
// rises in the same cycle.
module wildcard_packet_filter_classifier_top
	import wpfc_pkg::*;
#(
	parameter int MAX_FILTERS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [5:0]  write_address,
	input  logic [31:0] write_value,
	input  logic [1:0]  protocol,
	input  logic        is_ipv6,
	input  logic [31:0] src_ip,
	input  logic [31:0] dst_ip,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic        rtp_ok,
	input  logic [31:0] rtp_ssrc,
	input  logic [6:0]  rtp_payload_type,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic        match_valid,
	output logic [2:0]  match_index
);

	localparam int NumCells = (MAX_FILTERS < TableEntries) ? MAX_FILTERS : TableEntries;

	logic [3:0] num_filters_q;
	logic       adv;
	logic       nz;

	cell_bus_t  chain [NumCells+1];
	cell_bus_t  last;

	action_t    act_d;
	logic       hit_d;
	logic [2:0] idx_d;

	logic       out_valid_q;
	action_t    action_q;
	logic       match_valid_q;
	logic [2:0] match_index_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {28'd0, num_filters_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_filters_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			num_filters_q <= pwdata[3:0];
		end
	end

	assign adv = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	always_comb begin
		chain[0]          = '0;
		chain[0].valid    = in_valid;
		chain[0].op       = op;
		chain[0].waddr    = write_address;
		chain[0].wdata    = write_value;
		chain[0].protocol = protocol;
		chain[0].is_ipv6  = is_ipv6;
		chain[0].src_ip   = src_ip;
		chain[0].dst_ip   = dst_ip;
		chain[0].src_port = src_port;
		chain[0].dst_port = dst_port;
		chain[0].rtp_ok   = rtp_ok;
		chain[0].rtp_ssrc = rtp_ssrc;
		chain[0].rtp_pt   = rtp_payload_type;
	end

	for (genvar g = 0; g < NumCells; g++) begin : g_cell
		wpfc_cell #(.IDX(g)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.num_filters (num_filters_q),
			.bus_i       (chain[g]),
			.bus_o       (chain[g+1])
		);
	end

	assign last = chain[NumCells];
	assign nz = num_filters_q != '0;

	always_comb begin
		act_d = ACT_DROP;
		hit_d = 1'b0;
		idx_d = '0;
		if (last.op == OP_WRITE) begin
			act_d = ACT_WRITE;
		end else if (last.protocol == PROTO_TCP) begin
			if (!nz) begin
				act_d = ACT_TCP;
			end else if (last.raw_hit) begin
				act_d = ACT_TCP;
				hit_d = 1'b1;
				idx_d = last.raw_idx;
			end
		end else if (last.protocol == PROTO_UDP) begin
			priority if (nz && !last.raw_hit) begin
				act_d = ACT_DROP;
			end else if (!nz || last.want_rtp) begin
				if (!last.rtp_ok) begin
					act_d = ACT_DROP;
				end else if (!nz) begin
					act_d = ACT_RTP;
				end else if (last.rtp_hit) begin
					act_d = ACT_RTP;
					hit_d = 1'b1;
					idx_d = last.rtp_idx;
				end
			end else begin
				act_d = ACT_UDP;
				hit_d = 1'b1;
				idx_d = last.raw_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_q      <= act_d;
			match_valid_q <= hit_d;
			match_index_q <= idx_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign action      = action_q;
	assign match_valid = match_valid_q;
	assign match_index = match_index_q;

	a_write_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == ACT_WRITE) |-> !match_valid && (match_index == '0))
		else $error("write result carries a match");

	a_match_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_valid |->
			(action == ACT_TCP) || (action == ACT_RTP) || (action == ACT_UDP))
		else $error("match reported without an accept action");

	a_match_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_valid |-> (32'(match_index) < NumCells))
		else $error("match index beyond filter cells");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(action) && $stable(match_index))
		else $error("stalled result changed");

endmodule
